// ===== design/hlt_pkg.sv =====
`default_nettype none

package hlt_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam int ID_W    = 31;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;

  localparam logic FUNC_HEARTBEAT = 1'b0;
  localparam logic FUNC_SWEEP     = 1'b1;

  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd10;

endpackage

`default_nettype wire

// ===== design/hlt_cell.sv =====
`default_nettype none

module hlt_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      shift,
  input  wire logic [hlt_pkg::ID_W-1:0]    worker_in,
  input  wire logic [hlt_pkg::STAMP_W-1:0] stamp_in,
  output logic      [hlt_pkg::ID_W-1:0]    worker,
  output logic      [hlt_pkg::STAMP_W-1:0] slot_stamp
);
  import hlt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker <= '0;
    end else if (shift) begin
      worker <= worker_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      slot_stamp <= stamp_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/heartbeat_liveness_table.sv =====
// Heartbeat liveness table.
// Request channel: req_valid/req_stall with func, worker_id and stamp. A
// heartbeat (func 0) refreshes or enters a worker; a sweep (func 1) frees
// every active slot whose age has reached heartbeat_timeout.
// Response channel: rsp_valid/rsp_stall, one response per request, with the
// kill request, the counts and the restart need.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index 0 writes
// slot_count, 1 writes heartbeat_timeout. Write only while idle.
// The slots sit in a ring of cells that rotates one slot per cycle, while a
// request is scanned or filled, past a single compare point. A request takes
// one full turn of the ring, and a heartbeat that enters a new worker takes a
// second turn to write it. The response is registered in ST_DONE after the
// last turn; a new request is taken only once the state is back in ST_IDLE,
// so one request is handled at a time.
// The response register holds while rsp_stall is high; a finished request
// waits there and no new request is taken until it is loaded.
// Reset frees all slots, clears the counts, sets slot_count to 0 and the
// timeout to 10.
`default_nettype none

module heartbeat_liveness_table #(
  parameter int SLOTS = hlt_pkg::SLOTS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic                         func,
  input  wire logic [hlt_pkg::ID_W-1:0]     worker_id,
  input  wire logic [hlt_pkg::STAMP_W-1:0]  stamp,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic                              kill_request,
  output logic      [hlt_pkg::ID_W-1:0]     kill_id,
  output logic      [hlt_pkg::CNT_W-1:0]    alive_count,
  output logic      [hlt_pkg::STAMP_W-1:0]  dead_count,
  output logic      [hlt_pkg::CNT_W-1:0]    expired_now,
  output logic      [hlt_pkg::CNT_W-1:0]    restart_need,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hlt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hlt_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCNT_W = $clog2(SLOTS + 1);
  localparam int ACT_W  = (SCNT_W > CNT_W) ? SCNT_W : CNT_W;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state, state_next;

  logic [CNT_W-1:0]   slot_count;
  logic [STAMP_W-1:0] heartbeat_timeout;

  logic               op_func;
  logic [ID_W-1:0]    op_id;
  logic [STAMP_W-1:0] op_stamp;

  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] free_idx;
  logic             found, have_free, kill;
  logic             found_now;
  logic [CNT_W-1:0] freed, freed_next;
  logic [CNT_W-1:0] live_total;
  logic [STAMP_W-1:0] expired_total;

  logic [ID_W-1:0]    cell_w [SLOTS];
  logic [STAMP_W-1:0] cell_s [SLOTS];
  logic [ID_W-1:0]    head_w;
  logic [STAMP_W-1:0] head_s;
  logic               shift;

  logic [ACT_W-1:0] act;
  logic [ACT_W-1:0] live_ext;
  logic             pos_active;
  logic             hb_en;
  logic             hit_free, hit_match, hit_expire;
  logic [STAMP_W-1:0] age;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign shift     = (state == ST_SCAN) || (state == ST_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count        <= '0;
      heartbeat_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_COUNT: slot_count <= cfg_data[CNT_W-1:0];
        CFG_TIMEOUT:    heartbeat_timeout <= cfg_data[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign act = (ACT_W'(slot_count) < ACT_W'(SLOTS)) ? ACT_W'(slot_count) : ACT_W'(SLOTS);
  assign live_ext   = ACT_W'(live_total);
  assign pos_active = ACT_W'(pos) < act;
  assign hb_en      = (op_func == FUNC_HEARTBEAT) && (op_id != '0);
  assign age        = op_stamp - cell_s[0];

  assign hit_free   = (state == ST_SCAN) && pos_active && hb_en && !found &&
                      (cell_w[0] == '0);
  assign hit_match  = (state == ST_SCAN) && pos_active && hb_en && !found &&
                      (cell_w[0] != '0) && (cell_w[0] == op_id);
  assign hit_expire = (state == ST_SCAN) && pos_active && (op_func == FUNC_SWEEP) &&
                      (cell_w[0] != '0) && (age >= heartbeat_timeout);

  assign found_now  = found || hit_match;

  assign freed_next = hit_expire ? freed + CNT_W'(1) : freed;

  always_comb begin
    head_w = cell_w[0];
    head_s = cell_s[0];
    if (hit_match) begin
      head_s = op_stamp;
    end
    if (hit_expire) begin
      head_w = '0;
      head_s = '0;
    end
    if ((state == ST_FILL) && (pos == free_idx)) begin
      head_w = op_id;
      head_s = op_stamp;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      hlt_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .worker_in (head_w),
        .stamp_in  (head_s),
        .worker    (cell_w[i]),
        .slot_stamp(cell_s[i])
      );
    end else begin : g_body
      hlt_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .worker_in (cell_w[i+1]),
        .stamp_in  (cell_s[i+1]),
        .worker    (cell_w[i]),
        .slot_stamp(cell_s[i])
      );
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (pos == LAST_POS) begin
          if (hb_en && !found_now && !(live_ext >= act || !(have_free || hit_free))) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FILL: if (pos == LAST_POS) state_next = ST_DONE;
      ST_DONE: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      op_func  <= func;
      op_id    <= worker_id;
      op_stamp <= stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      free_idx      <= '0;
      found         <= 1'b0;
      have_free     <= 1'b0;
      kill          <= 1'b0;
      freed         <= '0;
      live_total    <= '0;
      expired_total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          pos       <= '0;
          found     <= 1'b0;
          have_free <= 1'b0;
          kill      <= 1'b0;
          freed     <= '0;
        end
        ST_SCAN: begin
          pos   <= (pos == LAST_POS) ? '0 : pos + IDX_W'(1);
          freed <= freed_next;
          if (hit_free) begin
            have_free <= 1'b1;
            free_idx  <= pos;
          end
          if (hit_match) begin
            found <= 1'b1;
          end
          if (pos == LAST_POS) begin
            if (op_func == FUNC_SWEEP) begin
              live_total    <= (live_total > freed_next) ? live_total - freed_next : '0;
              expired_total <= expired_total + STAMP_W'(freed_next);
            end else if (hb_en && !found_now) begin
              if (live_ext >= act || !(have_free || hit_free)) begin
                kill <= 1'b1;
              end else begin
                live_total <= live_total + CNT_W'(1);
              end
            end
          end
        end
        ST_FILL: begin
          pos <= (pos == LAST_POS) ? '0 : pos + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
      kill_request <= kill;
      kill_id      <= kill ? op_id : '0;
      alive_count  <= live_total;
      dead_count   <= expired_total;
      expired_now  <= freed;
      restart_need <= (act > live_ext) ? CNT_W'(act - live_ext) : '0;
    end
  end

endmodule

`default_nettype wire
